@@ rtl/cvh_pkg.sv @@
// shared constants, controller state type and control/status bundles for the convex hull block
`timescale 1ns / 1ps
package cvh_pkg;

    localparam int MAX_POINTS = 64;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int CNT_W      = PT_AW + 1;
    localparam int STK_DEPTH  = 2 * MAX_POINTS;
    localparam int STK_AW     = $clog2(STK_DEPTH);
    localparam int TOP_W      = STK_AW + 1;
    localparam int CRD_W      = 16;
    localparam int PT_W       = 2 * CRD_W;
    localparam int DIFF_W     = CRD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START,
        ST_SORT_LD,
        ST_SORT_LDW,
        ST_SORT_CHK,
        ST_SORT_CMP,
        ST_SORT_PUT,
        ST_HULL_INIT,
        ST_HULL_RD,
        ST_HULL_RDW,
        ST_HULL_CHK,
        ST_HULL_MUL,
        ST_HULL_CMP,
        ST_HULL_POPW,
        ST_HULL_PUSH,
        ST_EMIT_INIT,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_ONE_RD,
        ST_ONE_OUT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic sort_init;
        logic sort_ld;
        logic sort_ldw;
        logic sort_rd_prev;
        logic sort_shift;
        logic sort_put;
        logic hull_init;
        logic hull_rd;
        logic hull_capture;
        logic hull_mul;
        logic hull_pop;
        logic hull_popw;
        logic hull_push;
        logic emit_init;
        logic emit_rd;
        logic emit_out;
        logic one_rd;
        logic one_out;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic n_is_one;
        logic j_zero;
        logic before_hit;
        logic sort_more;
        logic may_pop;
        logic turn_le;
        logic hull_done;
        logic emit_last;
    } t_sts;

endpackage

@@ rtl/cvh_ctrl.sv @@
// sequencer for load, insertion sort, chain build and vertex output
`timescale 1ns / 1ps
module cvh_ctrl
    import cvh_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   start,
    input  logic   i_final_point,
    input  t_sts   i_sts,
    output t_cmd   o_cmd,
    output logic   busy
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start && i_final_point) n_state = ST_START;
            end
            ST_START:     n_state = i_sts.n_is_one ? ST_ONE_RD : ST_SORT_LD;
            ST_SORT_LD:   n_state = ST_SORT_LDW;
            ST_SORT_LDW:  n_state = ST_SORT_CHK;
            ST_SORT_CHK:  n_state = i_sts.j_zero ? ST_SORT_PUT : ST_SORT_CMP;
            ST_SORT_CMP:  n_state = i_sts.before_hit ? ST_SORT_CHK : ST_SORT_PUT;
            ST_SORT_PUT:  n_state = i_sts.sort_more ? ST_SORT_LD : ST_HULL_INIT;
            ST_HULL_INIT: n_state = ST_HULL_RD;
            ST_HULL_RD:   n_state = ST_HULL_RDW;
            ST_HULL_RDW:  n_state = ST_HULL_CHK;
            ST_HULL_CHK:  n_state = i_sts.may_pop ? ST_HULL_MUL : ST_HULL_PUSH;
            ST_HULL_MUL:  n_state = ST_HULL_CMP;
            ST_HULL_CMP:  n_state = i_sts.turn_le ? ST_HULL_POPW : ST_HULL_PUSH;
            ST_HULL_POPW: n_state = ST_HULL_CHK;
            ST_HULL_PUSH: n_state = i_sts.hull_done ? ST_EMIT_INIT : ST_HULL_RD;
            ST_EMIT_INIT: n_state = ST_EMIT_RD;
            ST_EMIT_RD:   n_state = ST_EMIT_OUT;
            ST_EMIT_OUT:  n_state = i_sts.emit_last ? ST_IDLE : ST_EMIT_RD;
            ST_ONE_RD:    n_state = ST_ONE_OUT;
            ST_ONE_OUT:   n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // command decode
    always_comb begin
        o_cmd              = '0;
        busy               = (r_state != ST_IDLE);
        o_cmd.load         = (r_state == ST_IDLE) && start;
        o_cmd.sort_init    = (r_state == ST_START);
        o_cmd.sort_ld      = (r_state == ST_SORT_LD);
        o_cmd.sort_ldw     = (r_state == ST_SORT_LDW);
        o_cmd.sort_rd_prev = (r_state == ST_SORT_CHK) && !i_sts.j_zero;
        o_cmd.sort_shift   = (r_state == ST_SORT_CMP) && i_sts.before_hit;
        o_cmd.sort_put     = (r_state == ST_SORT_PUT);
        o_cmd.hull_init    = (r_state == ST_HULL_INIT);
        o_cmd.hull_rd      = (r_state == ST_HULL_RD);
        o_cmd.hull_capture = (r_state == ST_HULL_RDW);
        o_cmd.hull_mul     = (r_state == ST_HULL_MUL);
        o_cmd.hull_pop     = (r_state == ST_HULL_CMP) && i_sts.turn_le;
        o_cmd.hull_popw    = (r_state == ST_HULL_POPW);
        o_cmd.hull_push    = (r_state == ST_HULL_PUSH);
        o_cmd.emit_init    = (r_state == ST_EMIT_INIT);
        o_cmd.emit_rd      = (r_state == ST_EMIT_RD);
        o_cmd.emit_out     = (r_state == ST_EMIT_OUT);
        o_cmd.one_rd       = (r_state == ST_ONE_RD);
        o_cmd.one_out      = (r_state == ST_ONE_OUT);
    end

endmodule

@@ rtl/cvh_dp.sv @@
// point store, hull stack, cross product and output registers
`timescale 1ns / 1ps
module cvh_dp
    import cvh_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic signed [CRD_W-1:0] i_point_x,
    input  logic signed [CRD_W-1:0] i_point_y,
    input  logic                    i_final_point,
    output t_sts                    o_sts,
    output logic signed [CRD_W-1:0] o_hull_x,
    output logic signed [CRD_W-1:0] o_hull_y,
    output logic                    o_hull_end,
    output logic                    o_hull_valid
);

    logic [PT_W-1:0]   r_store [0:MAX_POINTS-1];
    logic [PT_W-1:0]   r_stack [0:STK_DEPTH-1];
    logic [PT_W-1:0]   r_store_rd;
    logic [PT_W-1:0]   r_stack_rd;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_i;
    logic [CNT_W-1:0]  r_j;
    logic [CNT_W-1:0]  r_k;
    logic [CNT_W-1:0]  r_emit_cnt;
    logic [TOP_W-1:0]  r_top;
    logic [TOP_W-1:0]  r_floor;
    logic              r_lower;
    logic [PT_W-1:0]   r_p;
    logic [PT_W-1:0]   r_a;
    logic [PT_W-1:0]   r_b;
    logic signed [PROD_W-1:0] r_prod1;
    logic signed [PROD_W-1:0] r_prod2;

    logic              r_out_vld;
    logic [CRD_W-1:0]  r_out_x;
    logic [CRD_W-1:0]  r_out_y;
    logic              r_out_end;

    logic              store_we;
    logic [PT_AW-1:0]  store_wa;
    logic [PT_W-1:0]   store_wd;
    logic [PT_AW-1:0]  store_ra;
    logic              stack_we;
    logic [STK_AW-1:0] stack_ra;
    logic [CNT_W-1:0]  count_inc;
    logic [CNT_W-1:0]  i_dec;
    logic [CNT_W-1:0]  j_dec;
    logic [TOP_W-1:0]  top_dec;
    logic [TOP_W-1:0]  top_sub3;
    logic [TOP_W-1:0]  top_inc;
    logic signed [DIFF_W-1:0] abx;
    logic signed [DIFF_W-1:0] aby;
    logic signed [DIFF_W-1:0] bcx;
    logic signed [DIFF_W-1:0] bcy;
    logic signed [CRD_W-1:0]  px;
    logic signed [CRD_W-1:0]  py;
    logic signed [CRD_W-1:0]  dx;
    logic signed [CRD_W-1:0]  dy;

    assign count_inc = r_count + CNT_W'(1);
    assign i_dec     = r_i - CNT_W'(1);
    assign j_dec     = r_j - CNT_W'(1);
    assign top_dec   = r_top - TOP_W'(1);
    assign top_sub3  = r_top - TOP_W'(3);
    assign top_inc   = r_top + TOP_W'(1);

    // store write and read address selection
    always_comb begin
        store_we = 1'b0;
        store_wa = r_j[PT_AW-1:0];
        store_wd = r_p;
        store_ra = '0;
        if (i_cmd.load) begin
            store_we = !r_count[CNT_W-1];
            store_wa = r_count[PT_AW-1:0];
            store_wd = {i_point_x, i_point_y};
        end else if (i_cmd.sort_shift) begin
            store_we = 1'b1;
            store_wd = r_store_rd;
        end else if (i_cmd.sort_put) begin
            store_we = 1'b1;
        end
        if (i_cmd.sort_ld) begin
            store_ra = r_i[PT_AW-1:0];
        end else if (i_cmd.sort_rd_prev) begin
            store_ra = j_dec[PT_AW-1:0];
        end else if (i_cmd.hull_rd) begin
            store_ra = r_lower ? r_i[PT_AW-1:0] : i_dec[PT_AW-1:0];
        end else if (i_cmd.one_rd) begin
            store_ra = '0;
        end
    end

    // point store memory
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_wa] <= store_wd;
        end
        r_store_rd <= r_store[store_ra];
    end

    // stack memory
    assign stack_we = i_cmd.hull_push;
    assign stack_ra = i_cmd.emit_rd ? STK_AW'(r_k) : top_sub3[STK_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            r_stack[r_top[STK_AW-1:0]] <= r_p;
        end
        r_stack_rd <= r_stack[stack_ra];
    end

    // sort order test of the held point against the fetched one
    assign px = r_p[PT_W-1:CRD_W];
    assign py = r_p[CRD_W-1:0];
    assign dx = r_store_rd[PT_W-1:CRD_W];
    assign dy = r_store_rd[CRD_W-1:0];

    // edge vectors for the turn test
    assign abx = DIFF_W'($signed(r_b[PT_W-1:CRD_W])) - DIFF_W'($signed(r_a[PT_W-1:CRD_W]));
    assign aby = DIFF_W'($signed(r_b[CRD_W-1:0])) - DIFF_W'($signed(r_a[CRD_W-1:0]));
    assign bcx = DIFF_W'(px) - DIFF_W'($signed(r_b[PT_W-1:CRD_W]));
    assign bcy = DIFF_W'(py) - DIFF_W'($signed(r_b[CRD_W-1:0]));

    // status to controller
    always_comb begin
        o_sts.n_is_one   = (r_n == CNT_W'(1));
        o_sts.j_zero     = (r_j == '0);
        o_sts.before_hit = (px < dx) || ((px == dx) && (py < dy));
        o_sts.sort_more  = ((r_i + CNT_W'(1)) < r_n);
        o_sts.may_pop    = (r_top >= r_floor) && (r_top >= TOP_W'(2));
        o_sts.turn_le    = (r_prod1 <= r_prod2);
        o_sts.hull_done  = !r_lower && (r_i == CNT_W'(1));
        o_sts.emit_last  = ((r_k + CNT_W'(1)) == r_emit_cnt);
    end

    // counters and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.emit_out || i_cmd.one_out;
            if (i_cmd.load) begin
                if (i_final_point) begin
                    r_n     <= r_count[CNT_W-1] ? r_count : count_inc;
                    r_count <= '0;
                end else if (!r_count[CNT_W-1]) begin
                    r_count <= count_inc;
                end
            end
        end
    end

    // sort, hull and emit working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.sort_init) begin
            r_i <= CNT_W'(1);
        end
        if (i_cmd.sort_ldw) begin
            r_p <= r_store_rd;
            r_j <= r_i;
        end
        if (i_cmd.sort_shift) begin
            r_j <= j_dec;
        end
        if (i_cmd.sort_put) begin
            r_i <= r_i + CNT_W'(1);
        end
        if (i_cmd.hull_init) begin
            r_top   <= '0;
            r_floor <= TOP_W'(2);
            r_i     <= '0;
            r_lower <= 1'b1;
        end
        if (i_cmd.hull_capture) begin
            r_p <= r_store_rd;
        end
        if (i_cmd.hull_mul) begin
            r_prod1 <= abx * bcy;
            r_prod2 <= aby * bcx;
        end
        if (i_cmd.hull_pop) begin
            r_top <= top_dec;
            r_b   <= r_a;
        end
        if (i_cmd.hull_popw) begin
            r_a <= r_stack_rd;
        end
        if (i_cmd.hull_push) begin
            r_a   <= r_b;
            r_b   <= r_p;
            r_top <= top_inc;
            if (r_lower) begin
                if ((r_i + CNT_W'(1)) == r_n) begin
                    r_lower <= 1'b0;
                    r_i     <= r_n;
                    r_floor <= r_top + TOP_W'(2);
                end else begin
                    r_i <= r_i + CNT_W'(1);
                end
            end else begin
                r_i <= i_dec;
            end
        end
        if (i_cmd.emit_init) begin
            r_k <= '0;
            if (top_dec > TOP_W'(MAX_POINTS)) begin
                r_emit_cnt <= CNT_W'(MAX_POINTS);
            end else begin
                r_emit_cnt <= top_dec[CNT_W-1:0];
            end
        end
        if (i_cmd.emit_out) begin
            r_k <= r_k + CNT_W'(1);
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_out) begin
            r_out_x   <= r_stack_rd[PT_W-1:CRD_W];
            r_out_y   <= r_stack_rd[CRD_W-1:0];
            r_out_end <= o_sts.emit_last;
        end else if (i_cmd.one_out) begin
            r_out_x   <= r_store_rd[PT_W-1:CRD_W];
            r_out_y   <= r_store_rd[CRD_W-1:0];
            r_out_end <= 1'b1;
        end
    end

    assign o_hull_x     = $signed(r_out_x);
    assign o_hull_y     = $signed(r_out_y);
    assign o_hull_end   = r_out_end;
    assign o_hull_valid = r_out_vld;

endmodule

@@ rtl/convex_hull_monotone_chain.sv @@
// Convex hull top level: points load one per cycle while busy is low (start high accepts a
// point). The point marked final closes the set of up to 64 points; further points are dropped.
// Busy then stays high while the store is insertion sorted, the lower and upper chains are
// built (one shared multiplier pair), and the vertices go out, each on o_hull_x/o_hull_y for
// one cycle with o_hull_valid, the last with o_hull_end. The receiver cannot stall; results
// are not held. A one-point set returns that point.
`timescale 1ns / 1ps
module convex_hull_monotone_chain
    import cvh_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [CRD_W-1:0] i_point_x,
    input  logic signed [CRD_W-1:0] i_point_y,
    input  logic                    i_final_point,
    output logic signed [CRD_W-1:0] o_hull_x,
    output logic signed [CRD_W-1:0] o_hull_y,
    output logic                    o_hull_end,
    output logic                    o_hull_valid
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    cvh_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_final_point (i_final_point),
        .i_sts         (sts),
        .o_cmd         (cmd),
        .busy          (busy)
    );

    // storage and arithmetic
    cvh_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_final_point (i_final_point),
        .o_sts         (sts),
        .o_hull_x      (o_hull_x),
        .o_hull_y      (o_hull_y),
        .o_hull_end    (o_hull_end),
        .o_hull_valid  (o_hull_valid)
    );

endmodule
